@@ design/tmq_pkg.sv @@
// tmq_pkg: shared widths, cell entry layout and texel helpers for the tile map
// quad generator. No dependencies.
`timescale 1ns / 1ps

package tmq_pkg;

   localparam int CELL_XW     = 6;
   localparam int TILE_IN_W   = 13;
   localparam int TILE_IDX_W  = 12;
   localparam int FLIP_W      = 3;
   localparam int COLS_W      = 7;
   localparam int CFG_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int POS_W       = 14;
   localparam int TEX_W       = 16;
   // raw texel coordinate before saturation: 12b row * 9b pitch + margin + size
   localparam int TEXR_W      = 23;

   localparam int MAP_W_DEFAULT    = 64;
   localparam int MAP_H_DEFAULT    = 64;
   localparam int MARGIN_X_DEFAULT = 0;
   localparam int MARGIN_Y_DEFAULT = 0;

   localparam int VERTS_PER_QUAD = 6;
   localparam int DIV_STEPS      = 2;   // quotient bits per divider cycle

   localparam logic [TEX_W-1:0] TEX_MAX = '1;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_DRAW  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TILESET_COLUMNS = 3'd0,
      REG_TILE_WIDTH      = 3'd1,
      REG_TILE_HEIGHT     = 3'd2,
      REG_SPACING_X       = 3'd3,
      REG_SPACING_Y       = 3'd4,
      REG_BLOCK_WIDTH     = 3'd5,
      REG_BLOCK_HEIGHT    = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic                  valid;
      logic [FLIP_W-1:0]     flip;    // bit0 diagonal, bit1 horizontal, bit2 vertical
      logic [TILE_IDX_W-1:0] tile;
   } cell_type;

   localparam cell_type NO_TILE = '0;

   typedef struct packed {
      logic [TEX_W-1:0] x;
      logic [TEX_W-1:0] y;
   } tex_pt_type;

   function automatic logic [TEX_W-1:0] sat_tex(input logic [TEXR_W-1:0] v);
      logic [TEX_W-1:0] r;
      if (v > TEXR_W'(TEX_MAX)) begin
         r = TEX_MAX;
      end else begin
         r = v[TEX_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/tmq_if.sv @@
// Request, vertex and register-write channels of the tile map quad generator.
// Depends on tmq_pkg.
`timescale 1ns / 1ps

interface tmq_req_if import tmq_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [CELL_XW-1:0]          cell_x;
   logic [CELL_XW-1:0]          cell_y;
   logic signed [TILE_IN_W-1:0] tile;
   logic [FLIP_W-1:0]           flip;

   modport source (output valid, op, cell_x, cell_y, tile, flip, input ready);
   modport sink   (input valid, op, cell_x, cell_y, tile, flip, output ready);
endinterface

interface tmq_rsp_if import tmq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [TEX_W-1:0] tex_x;
   logic [TEX_W-1:0] tex_y;
   logic             last;

   modport source (output valid, pos_x, pos_y, tex_x, tex_y, last, input ready);
   modport sink   (input valid, pos_x, pos_y, tex_x, tex_y, last, output ready);
endinterface

interface tmq_csr_if import tmq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/tmq_cell_mem.sv @@
// tmq_cell_mem: single-port-write, registered-read cell store with a clearing
// sweep after reset. Depends on tmq_pkg.
`timescale 1ns / 1ps

module tmq_cell_mem import tmq_pkg::*; #(
   parameter int DEPTH = MAP_W_DEFAULT * MAP_H_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  cell_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output cell_type      rd_data,
   output logic          clear_busy
);

   cell_type      cell_mem_ff [DEPTH];
   cell_type      rd_data_ff;
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   logic          we;
   logic [AW-1:0] waddr;
   cell_type      wdata;

   always_comb begin
      we    = clr_busy_ff | wr_en;
      waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
      wdata = clr_busy_ff ? NO_TILE : wr_data;
   end

   // one entry per cycle until the whole map reads empty
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // reads and writes never target the same cycle: one request at a time
   always_ff @(posedge clock) begin
      if (we) begin
         cell_mem_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem_ff[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

@@ design/tmq_div.sv @@
// tmq_div: restoring divider for tile index by tileset column count, DIV_STEPS
// quotient bits per cycle. Depends on tmq_pkg.
`timescale 1ns / 1ps

module tmq_div import tmq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TILE_IDX_W-1:0] dividend,
   input  logic [COLS_W-1:0]     divisor,    // never zero
   output logic                  done,
   output logic [TILE_IDX_W-1:0] quot,
   output logic [COLS_W-1:0]     rem
);

   localparam int ITER  = TILE_IDX_W / DIV_STEPS;
   localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

   logic [TILE_IDX_W-1:0] quo_ff, quo_in;
   logic [COLS_W-1:0]     rem_ff, rem_in;
   logic [COLS_W-1:0]     dsr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   always_comb begin
      logic [COLS_W:0]       t;
      logic [TILE_IDX_W-1:0] q;
      logic [COLS_W-1:0]     r;
      q = quo_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {r, q[TILE_IDX_W-1]};
         q = {q[TILE_IDX_W-2:0], 1'b0};
         if (t >= {1'b0, dsr_ff}) begin
            t    = t - {1'b0, dsr_ff};
            q[0] = 1'b1;
         end
         r = t[COLS_W-1:0];
      end
      quo_in = q;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

@@ design/tile_map_quad_generator.sv @@
// tile_map_quad_generator: cell map store plus quad vertex sequencer; uses tmq_pkg, tmq_if.
// Writes and off-map draws end on acceptance; an empty draw ends after check. A drawn cell
// passes read, check, divider steps plus done, multiply, corners, six vertices (held under stall).
// Reset: registers to defaults, then a clearing sweep of min(MAP_W,64)*min(MAP_H,64)
// entries (4096 by default) with req.ready low; register writes are taken throughout.
`timescale 1ns / 1ps

module tile_map_quad_generator import tmq_pkg::*; #(
   parameter int MAP_W    = MAP_W_DEFAULT,
   parameter int MAP_H    = MAP_H_DEFAULT,
   parameter int MARGIN_X = MARGIN_X_DEFAULT,
   parameter int MARGIN_Y = MARGIN_Y_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tmq_req_if.sink   req,
   tmq_rsp_if.source rsp,
   tmq_csr_if.sink   csr
);

   localparam int CELL_LIM = 2 ** CELL_XW;
   localparam int EFF_W    = (MAP_W < CELL_LIM) ? MAP_W : CELL_LIM;
   localparam int EFF_H    = (MAP_H < CELL_LIM) ? MAP_H : CELL_LIM;
   localparam int DEPTH    = EFF_W * EFF_H;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VCNT_W   = $clog2(VERTS_PER_QUAD);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_CORNER,
      ST_EMIT
   } state_type;

   // configuration
   logic [COLS_W-1:0] cols_ff;
   logic [CFG_W-1:0]  tw_ff, th_ff, sx_ff, sy_ff, bw_ff, bh_ff;

   state_type          state_ff;
   logic [CELL_XW-1:0] cx_ff, cy_ff;
   logic [FLIP_W-1:0]  flip_ff;
   logic [TEXR_W-1:0]  tx0_ff, ty0_ff;
   logic [POS_W-1:0]   px0_ff, py0_ff, px1_ff, py1_ff;
   tex_pt_type         tl_ff, tr_ff, bl_ff, br_ff;
   logic [VCNT_W-1:0]  vtx_ff;

   logic          accept;
   logic          in_map;
   logic [AW-1:0] req_addr;
   cell_type      new_cell;
   cell_type      rd_cell;
   logic          clear_busy;
   logic          div_start;
   logic          div_done;
   logic [TILE_IDX_W-1:0] div_quot;
   logic [COLS_W-1:0]     div_rem;
   logic [COLS_W-1:0]     cols_eff;

   logic [CFG_W-1:0]  bw_sel, bh_sel;
   logic [CFG_W:0]    pitch_x, pitch_y;
   logic [TEX_W-1:0]  prod_x;
   logic [TEXR_W-2:0] prod_y;
   logic [POS_W-1:0]  px0_raw, py0_raw;
   tex_pt_type        tl_c, tr_c, bl_c, br_c, tmp_c;
   logic [TEX_W-1:0]  sx0, sx1, sy0, sy1;

   // ---------------------------------------------------------------- requests
   assign req.ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req.valid && req.ready;
   assign in_map    = (int'(req.cell_x) < MAP_W) && (int'(req.cell_y) < MAP_H);
   assign req_addr  = AW'(int'(req.cell_y) * EFF_W + int'(req.cell_x));

   always_comb begin
      new_cell = NO_TILE;
      if (!req.tile[TILE_IN_W-1]) begin
         new_cell.valid = 1'b1;
         new_cell.flip  = req.flip;
         new_cell.tile  = req.tile[TILE_IDX_W-1:0];
      end
   end

   tmq_cell_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && (req.op == OP_WRITE) && in_map),
      .wr_addr    (req_addr),
      .wr_data    (new_cell),
      .rd_en      (accept && (req.op == OP_DRAW) && in_map),
      .rd_addr    (req_addr),
      .rd_data    (rd_cell),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------- registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_W'(1);
         tw_ff   <= '0;
         th_ff   <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         bw_ff   <= '0;
         bh_ff   <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_TILESET_COLUMNS: cols_ff <= csr.data[COLS_W-1:0];
            REG_TILE_WIDTH:      tw_ff   <= csr.data;
            REG_TILE_HEIGHT:     th_ff   <= csr.data;
            REG_SPACING_X:       sx_ff   <= csr.data;
            REG_SPACING_Y:       sy_ff   <= csr.data;
            REG_BLOCK_WIDTH:     bw_ff   <= csr.data;
            REG_BLOCK_HEIGHT:    bh_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- divider
   assign cols_eff  = (cols_ff == '0) ? COLS_W'(1) : cols_ff;
   assign div_start = (state_ff == ST_CHECK) && rd_cell.valid &&
                      (tw_ff != '0) && (th_ff != '0);

   tmq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_cell.tile),
      .divisor  (cols_eff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // ---------------------------------------------------------------- datapath
   always_comb begin
      // block size falls back to tile size only when both are zero
      if ((bw_ff == '0) && (bh_ff == '0)) begin
         bw_sel = tw_ff;
         bh_sel = th_ff;
      end else begin
         bw_sel = bw_ff;
         bh_sel = bh_ff;
      end
      pitch_x = {1'b0, tw_ff} + {1'b0, sx_ff};
      pitch_y = {1'b0, th_ff} + {1'b0, sy_ff};
      prod_x  = div_rem * pitch_x;
      prod_y  = div_quot * pitch_y;
      px0_raw = cx_ff * bw_sel;
      py0_raw = cy_ff * bh_sel;
   end

   always_comb begin
      tmp_c = '0;
      sx0 = sat_tex(tx0_ff);
      sy0 = sat_tex(ty0_ff);
      sx1 = sat_tex(tx0_ff + TEXR_W'(tw_ff));
      sy1 = sat_tex(ty0_ff + TEXR_W'(th_ff));
      tl_c = '{x: sx0, y: sy0};
      tr_c = '{x: sx1, y: sy0};
      bl_c = '{x: sx0, y: sy1};
      br_c = '{x: sx1, y: sy1};
      if (flip_ff[0]) begin   // diagonal
         tmp_c = tr_c; tr_c = bl_c; bl_c = tmp_c;
      end
      if (flip_ff[1]) begin   // horizontal
         tmp_c = tl_c; tl_c = tr_c; tr_c = tmp_c;
         tmp_c = bl_c; bl_c = br_c; br_c = tmp_c;
      end
      if (flip_ff[2]) begin   // vertical
         tmp_c = tl_c; tl_c = bl_c; bl_c = tmp_c;
         tmp_c = tr_c; tr_c = br_c; br_c = tmp_c;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vtx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req.op == OP_DRAW) && in_map) begin
                  cx_ff    <= req.cell_x;
                  cy_ff    <= req.cell_y;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               flip_ff <= rd_cell.flip;
               if (div_start) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               tx0_ff   <= TEXR_W'(prod_x) + TEXR_W'(MARGIN_X);
               ty0_ff   <= TEXR_W'(prod_y) + TEXR_W'(MARGIN_Y);
               px0_ff   <= px0_raw;
               py0_ff   <= py0_raw;
               px1_ff   <= px0_raw + POS_W'(bw_sel);
               py1_ff   <= py0_raw + POS_W'(bh_sel);
               state_ff <= ST_CORNER;
            end
            ST_CORNER: begin
               tl_ff    <= tl_c;
               tr_ff    <= tr_c;
               bl_ff    <= bl_c;
               br_ff    <= br_c;
               vtx_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp.ready) begin
                  if (vtx_ff == VCNT_W'(VERTS_PER_QUAD - 1)) begin
                     vtx_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     vtx_ff <= vtx_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- vertices
   // two triangles: TL TR BL, BL TR BR; texels follow the flips, positions do not
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.last  = (vtx_ff == VCNT_W'(VERTS_PER_QUAD - 1));

   always_comb begin
      case (vtx_ff)
         3'd0: begin
            rsp.pos_x = px0_ff; rsp.pos_y = py0_ff;
            rsp.tex_x = tl_ff.x; rsp.tex_y = tl_ff.y;
         end
         3'd1, 3'd4: begin
            rsp.pos_x = px1_ff; rsp.pos_y = py0_ff;
            rsp.tex_x = tr_ff.x; rsp.tex_y = tr_ff.y;
         end
         3'd2, 3'd3: begin
            rsp.pos_x = px0_ff; rsp.pos_y = py1_ff;
            rsp.tex_x = bl_ff.x; rsp.tex_y = bl_ff.y;
         end
         default: begin
            rsp.pos_x = px1_ff; rsp.pos_y = py1_ff;
            rsp.tex_x = br_ff.x; rsp.tex_y = br_ff.y;
         end
      endcase
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for tile_map_quad_generator. It drives cell writes, cell
// draws and register writes with random stalls and checks every vertex against a local model.
// Depends on tmq_pkg, tmq_if and the generator RTL.

module tb_top;
   import tmq_pkg::*;

   localparam int STALL_LIMIT   = 20000;   // covers the post-reset clear sweep several times
   localparam int SETTLE_CYCLES = 24;
   localparam int MAX_REPORTS   = 10;
   localparam int RAND_PHASES   = 6;
   localparam int PHASE_ITEMS   = 43;
   localparam int POOL_SIZE     = 8;
   localparam int MAP_CELLS     = MAP_W_DEFAULT * MAP_H_DEFAULT;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [TEX_W-1:0] tex_x;
      logic [TEX_W-1:0] tex_y;
      logic             last;
   } vertex_type;

   typedef struct {
      bit                          is_reg;
      reg_idx_type                 idx;
      logic [CFG_W-1:0]            data;
      op_type                      op;
      logic [CELL_XW-1:0]          cx;
      logic [CELL_XW-1:0]          cy;
      logic signed [TILE_IN_W-1:0] tile;
      logic [FLIP_W-1:0]           flip;
      bit                          no_vertex;   // typed in: this request draws nothing
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmq_req_if req_bus ();
   tmq_rsp_if rsp_bus ();
   tmq_csr_if csr_bus ();

   tile_map_quad_generator DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the cell map and registers
   cell_type           map_cells [0:MAP_CELLS-1];
   logic [COLS_W-1:0]  m_cols;
   logic [CFG_W-1:0]   m_tw, m_th, m_sx, m_sy, m_bw, m_bh;

   vertex_type         quad_verts_due [$];
   plan_row_type       plan_rows [$];

   bit                 idle_on = 1'b1;
   int                 error_count   = 0;
   int                 cells_written = 0;
   int                 cells_drawn   = 0;
   int                 verts_checked = 0;
   int                 regs_written  = 0;
   int                 quiet_cycles  = 0;
   vertex_type         got_vert, want_vert;

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endfunction

   function automatic string vert_str(input vertex_type v);
      return $sformatf("pos=(%0d,%0d) tex=(%0d,%0d) last=%0b",
                       v.pos_x, v.pos_y, v.tex_x, v.tex_y, v.last);
   endfunction

   function automatic logic [TEX_W-1:0] clamp_texel(input int unsigned v);
      return (v > 32'(TEX_MAX)) ? TEX_MAX : TEX_W'(v);
   endfunction

   function automatic vertex_type make_vert(input int unsigned px, input int unsigned py,
                                            input tex_pt_type pt, input logic last);
      vertex_type v;
      v.pos_x = POS_W'(px);
      v.pos_y = POS_W'(py);
      v.tex_x = pt.x;
      v.tex_y = pt.y;
      v.last  = last;
      return v;
   endfunction

   // Applies one accepted request to the local map and queues the quad it draws.
   function automatic void model_request(input op_type op, input logic [CELL_XW-1:0] cx,
                                         input logic [CELL_XW-1:0] cy,
                                         input logic signed [TILE_IN_W-1:0] tile,
                                         input logic [FLIP_W-1:0] flip, input bit keep);
      int unsigned addr, cols, col, row, bw, bh, px0, py0, px1, py1, tx0, ty0;
      cell_type    entry;
      tex_pt_type  tl, tr, bl, br, tmp;
      if (cx >= MAP_W_DEFAULT || cy >= MAP_H_DEFAULT) begin
         return;
      end
      addr = cy * MAP_W_DEFAULT + cx;
      if (op == OP_WRITE) begin
         if (tile[TILE_IN_W-1]) begin
            map_cells[addr] = NO_TILE;
         end else begin
            entry.valid = 1'b1;
            entry.flip  = flip;
            entry.tile  = tile[TILE_IDX_W-1:0];
            map_cells[addr] = entry;
         end
         return;
      end
      entry = map_cells[addr];
      if (!entry.valid || m_tw == 0 || m_th == 0) begin
         return;
      end
      cols = (m_cols == 0) ? 1 : m_cols;
      col  = entry.tile % cols;
      row  = entry.tile / cols;
      // block size falls back to tile size only when both block registers are zero
      if (m_bw == 0 && m_bh == 0) begin
         bw = m_tw;
         bh = m_th;
      end else begin
         bw = m_bw;
         bh = m_bh;
      end
      px0 = cx * bw;
      py0 = cy * bh;
      px1 = px0 + bw;
      py1 = py0 + bh;
      tx0 = col * (32'(m_tw) + 32'(m_sx)) + MARGIN_X_DEFAULT;
      ty0 = row * (32'(m_th) + 32'(m_sy)) + MARGIN_Y_DEFAULT;
      tl.x = clamp_texel(tx0);         tl.y = clamp_texel(ty0);
      tr.x = clamp_texel(tx0 + m_tw);  tr.y = clamp_texel(ty0);
      bl.x = clamp_texel(tx0);         bl.y = clamp_texel(ty0 + m_th);
      br.x = clamp_texel(tx0 + m_tw);  br.y = clamp_texel(ty0 + m_th);
      if (entry.flip[0]) begin
         tmp = tr; tr = bl; bl = tmp;
      end
      if (entry.flip[1]) begin
         tmp = tl; tl = tr; tr = tmp;
         tmp = bl; bl = br; br = tmp;
      end
      if (entry.flip[2]) begin
         tmp = tl; tl = bl; bl = tmp;
         tmp = tr; tr = br; br = tmp;
      end
      if (keep) begin
         quad_verts_due.push_back(make_vert(px0, py0, tl, 1'b0));
         quad_verts_due.push_back(make_vert(px1, py0, tr, 1'b0));
         quad_verts_due.push_back(make_vert(px0, py1, bl, 1'b0));
         quad_verts_due.push_back(make_vert(px0, py1, bl, 1'b0));
         quad_verts_due.push_back(make_vert(px1, py0, tr, 1'b0));
         quad_verts_due.push_back(make_vert(px1, py1, br, 1'b1));
      end
   endfunction

   function automatic void add_cell(input op_type op, input int cx, input int cy,
                                    input logic signed [TILE_IN_W-1:0] tile,
                                    input int flip, input bit no_vertex);
      plan_row_type r;
      r.is_reg    = 1'b0;
      r.idx       = REG_TILESET_COLUMNS;
      r.data      = '0;
      r.op        = op;
      r.cx        = CELL_XW'(cx);
      r.cy        = CELL_XW'(cy);
      r.tile      = tile;
      r.flip      = FLIP_W'(flip);
      r.no_vertex = no_vertex;
      plan_rows.push_back(r);
   endfunction

   function automatic void add_reg(input reg_idx_type idx, input logic [CFG_W-1:0] data);
      plan_row_type r;
      r.is_reg    = 1'b1;
      r.idx       = idx;
      r.data      = data;
      r.op        = OP_WRITE;
      r.cx        = '0;
      r.cy        = '0;
      r.tile      = '0;
      r.flip      = '0;
      r.no_vertex = 1'b1;
      plan_rows.push_back(r);
   endfunction

   function automatic logic [CFG_W-1:0] pick_byte(input int lo);
      case ($urandom_range(0, 4))
         0: return CFG_W'(lo);
         1: return '1;
         default: return CFG_W'($urandom_range(lo, 255));
      endcase
   endfunction

   function automatic logic [CELL_XW-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return CELL_XW'($urandom_range(0, 63));
      endcase
   endfunction

   task automatic send_cell(input op_type op, input logic [CELL_XW-1:0] cx,
                            input logic [CELL_XW-1:0] cy,
                            input logic signed [TILE_IN_W-1:0] tile,
                            input logic [FLIP_W-1:0] flip, input bit no_vertex);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.cell_x <= cx;
      req_bus.cell_y <= cy;
      req_bus.tile   <= tile;
      req_bus.flip   <= flip;
      do @(posedge clock); while (!req_bus.ready);
      model_request(op, cx, cy, tile, flip, !no_vertex);
      if (op == OP_WRITE) begin
         cells_written++;
      end else begin
         cells_drawn++;
      end
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_TILESET_COLUMNS: m_cols = data[COLS_W-1:0];
         REG_TILE_WIDTH:      m_tw   = data;
         REG_TILE_HEIGHT:     m_th   = data;
         REG_SPACING_X:       m_sx   = data;
         REG_SPACING_Y:       m_sy   = data;
         REG_BLOCK_WIDTH:     m_bw   = data;
         REG_BLOCK_HEIGHT:    m_bh   = data;
         default: ;
      endcase
      regs_written++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Drop valid, let every queued vertex come back, then give write/empty requests time.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (quad_verts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // vertex receiver with random back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_vert.pos_x = rsp_bus.pos_x;
         got_vert.pos_y = rsp_bus.pos_y;
         got_vert.tex_x = rsp_bus.tex_x;
         got_vert.tex_y = rsp_bus.tex_y;
         got_vert.last  = rsp_bus.last;
         if (quad_verts_due.size() == 0) begin
            report_error({"vertex with none pending: ", vert_str(got_vert)});
         end else begin
            want_vert = quad_verts_due.pop_front();
            verts_checked++;
            if (got_vert.pos_x !== want_vert.pos_x || got_vert.pos_y !== want_vert.pos_y ||
                got_vert.tex_x !== want_vert.tex_x || got_vert.tex_y !== want_vert.tex_y ||
                got_vert.last !== want_vert.last) begin
               report_error({"vertex mismatch: expected ", vert_str(want_vert),
                             " got ", vert_str(got_vert)});
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d vertices pending",
                  quiet_cycles, quad_verts_due.size());
         $display("tile_map_quad_generator test failed");
         $finish;
      end
   end

   initial begin
      logic [CELL_XW-1:0]          pool_x [POOL_SIZE];
      logic [CELL_XW-1:0]          pool_y [POOL_SIZE];
      logic [CELL_XW-1:0]          cx, cy;
      logic signed [TILE_IN_W-1:0] tile;
      op_type                      op;
      int                          j;

      req_bus.valid  = 1'b0;
      req_bus.op     = OP_WRITE;
      req_bus.cell_x = '0;
      req_bus.cell_y = '0;
      req_bus.tile   = '0;
      req_bus.flip   = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = REG_TILESET_COLUMNS;
      csr_bus.data   = '0;

      for (int i = 0; i < MAP_CELLS; i++) begin
         map_cells[i] = NO_TILE;
      end
      m_cols = 1;
      m_tw = '0; m_th = '0; m_sx = '0; m_sy = '0; m_bw = '0; m_bh = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests
      add_cell(OP_DRAW,  0,  0, 0, 0, 1);            // empty after reset
      add_cell(OP_WRITE, 0,  0, 5, 0, 1);
      add_cell(OP_DRAW,  0,  0, 0, 0, 1);            // tile size still zero
      add_reg(REG_TILE_WIDTH, 8'd8);
      add_reg(REG_TILE_HEIGHT, 8'd8);
      add_cell(OP_DRAW,  0,  0, 0, 0, 0);
      add_cell(OP_DRAW,  63, 63, 0, 0, 1);           // never written
      add_cell(OP_WRITE, 63, 63, 4095, 7, 1);
      add_cell(OP_DRAW,  63, 63, -1, 7, 0);
      for (int f = 1; f < 7; f++) begin
         add_cell(OP_WRITE, f, 1, TILE_IN_W'(f), f, 1);
         add_cell(OP_DRAW,  f, 1, 0, 0, 0);
      end
      add_reg(REG_TILESET_COLUMNS, 8'd0);            // acts as one column
      add_reg(REG_TILE_WIDTH, 8'hFF);
      add_reg(REG_TILE_HEIGHT, 8'hFF);
      add_reg(REG_SPACING_X, 8'hFF);
      add_reg(REG_SPACING_Y, 8'hFF);
      add_reg(REG_BLOCK_WIDTH, 8'd0);                // only one block reg zero: no fallback
      add_reg(REG_BLOCK_HEIGHT, 8'd5);
      add_cell(OP_DRAW,  63, 63, 0, 0, 0);           // texel y saturates
      add_cell(OP_WRITE, 2, 2, -1, 5, 1);
      add_cell(OP_DRAW,  2, 2, 0, 0, 1);
      add_cell(OP_WRITE, 3, 3, 13'h1000, 7, 1);      // most negative tile is empty too
      add_cell(OP_DRAW,  3, 3, 0, 0, 1);
      add_reg(REG_TILESET_COLUMNS, 8'hFF);           // masked to 127
      add_reg(REG_BLOCK_WIDTH, 8'hFF);
      add_reg(REG_BLOCK_HEIGHT, 8'hFF);
      add_cell(OP_DRAW,  63, 63, 0, 0, 0);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_reg) begin
            if (i > 0 && !plan_rows[i-1].is_reg) begin
               wait_idle();
            end
            write_reg(plan_rows[i].idx, plan_rows[i].data);
         end else begin
            send_cell(plan_rows[i].op, plan_rows[i].cx, plan_rows[i].cy, plan_rows[i].tile,
                      plan_rows[i].flip, plan_rows[i].no_vertex);
         end
      end

      // random phases, each with its own register setting
      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == RAND_PHASES - 1) begin
            idle_on = 1'b0;
         end
         wait_idle();
         case ($urandom_range(0, 4))
            0: write_reg(REG_TILESET_COLUMNS, 8'd0);
            1: write_reg(REG_TILESET_COLUMNS, 8'hFF);
            2: write_reg(REG_TILESET_COLUMNS, 8'd64);
            default: write_reg(REG_TILESET_COLUMNS, CFG_W'($urandom_range(1, 64)));
         endcase
         write_reg(REG_TILE_WIDTH,  ($urandom_range(0, 9) == 0) ? '0 : pick_byte(1));
         write_reg(REG_TILE_HEIGHT, ($urandom_range(0, 9) == 0) ? '0 : pick_byte(1));
         write_reg(REG_SPACING_X, pick_byte(0));
         write_reg(REG_SPACING_Y, pick_byte(0));
         case ($urandom_range(0, 5))
            0, 1: begin
               write_reg(REG_BLOCK_WIDTH, '0);
               write_reg(REG_BLOCK_HEIGHT, '0);
            end
            2: begin
               write_reg(REG_BLOCK_WIDTH, '0);
               write_reg(REG_BLOCK_HEIGHT, pick_byte(1));
            end
            3: begin
               write_reg(REG_BLOCK_WIDTH, pick_byte(1));
               write_reg(REG_BLOCK_HEIGHT, '0);
            end
            default: begin
               write_reg(REG_BLOCK_WIDTH, pick_byte(1));
               write_reg(REG_BLOCK_HEIGHT, pick_byte(1));
            end
         endcase

         // keep traffic on a few hot cells so draws mostly find written tiles
         for (int k = 0; k < POOL_SIZE; k++) begin
            pool_x[k] = pick_coord();
            pool_y[k] = pick_coord();
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_DRAW;
            if ($urandom_range(0, 3) != 0) begin
               j  = $urandom_range(0, POOL_SIZE - 1);
               cx = pool_x[j];
               cy = pool_y[j];
            end else begin
               cx = pick_coord();
               cy = pick_coord();
            end
            case ($urandom_range(0, 9))
               0: tile = -1;
               1: tile = TILE_IN_W'($urandom_range(0, 4095)) | 13'h1000;
               2: tile = '0;
               3: tile = 13'd4095;
               default: tile = TILE_IN_W'($urandom_range(0, 4095));
            endcase
            send_cell(op, cx, cy, tile, FLIP_W'($urandom_range(0, 7)), 1'b0);
         end
      end

      wait_idle();
      $display("summary: %0d cell writes, %0d draws, %0d vertices checked, %0d register writes",
               cells_written, cells_drawn, verts_checked, regs_written);
      $display("summary: %0d register settings incl. zero/max sizes and flip combos, %0d errors",
               RAND_PHASES + 3, error_count);
      if (error_count == 0) begin
         $display("tile_map_quad_generator test passed");
      end else begin
         $display("tile_map_quad_generator test failed");
      end
      $finish;
   end

endmodule
